FILE: sv/rlpg_pkg.sv
`default_nettype none
package rlpg_pkg;

  localparam int DT_W       = 16;
  localparam int PHASE_W    = 16;
  localparam int SPEED_W    = 16;
  localparam int SPAN_W     = 7;
  localparam int COUNT_W    = 7;
  localparam int IDX_W      = 6;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_SHIFT = 12;
  localparam int PROD_W     = DT_W + SPEED_W;
  localparam int STEP_CNT_W = 4;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd4096;

  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_HUE_SPAN    = 2'd1,
    CFG_PIXEL_COUNT = 2'd2,
    CFG_SPIN_RATE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage
`default_nettype wire

FILE: sv/rlpg_req_if.sv
`default_nettype none
interface rlpg_req_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [rlpg_pkg::DT_W-1:0]  dt;

  modport source (output valid, output func, output dt, input ready);
  modport sink (input valid, input func, input dt, output ready);
endinterface
`default_nettype wire

FILE: sv/rlpg_pix_if.sv
`default_nettype none
interface rlpg_pix_if;
  logic                       valid;
  logic                       ready;
  logic [rlpg_pkg::IDX_W-1:0] pixel_index;
  logic [rlpg_pkg::CH_W-1:0]  red;
  logic [rlpg_pkg::CH_W-1:0]  green;
  logic [rlpg_pkg::CH_W-1:0]  blue;
  logic                       last;

  modport source (output valid, output pixel_index, output red, output green, output blue,
                  output last, input ready);
  modport sink (input valid, input pixel_index, input red, input green, input blue,
                input last, output ready);
endinterface
`default_nettype wire

FILE: sv/rainbow_led_pattern_generator_unit.sv
// channel  role   payload                                   transaction
// req      sink   func, dt                                  valid & ready
// pix      source pixel_index, red, green, blue, last       valid & ready
// cfg      write  cfg_index, cfg_data                       cfg_we
//
// tick: one bit of dt per cycle through the serial multiplier
// render: each pixel goes through the 16-step serial divider
// req is taken only between items; a held pix stalls the next pixel
// rst is synchronous: phase 0, registers to their defaults, pix empty
`default_nettype none
module rainbow_led_pattern_generator_unit #(
  parameter int MAX_PIXELS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rlpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlpg_pkg::CFG_DATA_W-1:0]  cfg_data,
  rlpg_req_if.sink                         req,
  rlpg_pix_if.source                       pix
);
  import rlpg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_DIV,
    S_COLOR,
    S_EMIT
  } state_t;

  state_t               state;
  logic                 enable;
  logic [SPAN_W-1:0]    hue_span;
  logic [COUNT_W-1:0]   pixel_count;
  logic [SPEED_W-1:0]   spin_rate;
  logic [PHASE_W-1:0]   phase;
  logic [COUNT_W-1:0]   n;
  logic [COUNT_W-1:0]   n_next;
  logic [COUNT_W-1:0]   pix_i;
  logic [SPAN_W-1:0]    pos;
  logic                 mul_start;
  logic                 mul_done;
  logic [PHASE_W-1:0]   mul_result;
  logic                 div_start;
  logic                 div_done;
  logic [PHASE_W-1:0]   div_quo;
  logic                 hue_start;
  logic                 hue_valid;
  rgb_t                 hue_rgb;
  logic                 req_acc;
  logic                 is_last;
  logic                 pix_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      hue_span    <= '0;
      pixel_count <= '0;
      spin_rate   <= SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ENABLE:      enable      <= cfg_data[0];
        CFG_HUE_SPAN:    hue_span    <= cfg_data[SPAN_W-1:0];
        CFG_PIXEL_COUNT: pixel_count <= cfg_data[COUNT_W-1:0];
        CFG_SPIN_RATE:   spin_rate   <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_next    = (pixel_count > COUNT_W'(MAX_PIXELS)) ? COUNT_W'(MAX_PIXELS) : pixel_count;
  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign is_last   = (pix_i + 1'b1) == n;
  assign pix_free  = !pix.valid || pix.ready;

  rlpg_serial_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (req.dt),
    .b      (spin_rate),
    .done   (mul_done),
    .result (mul_result)
  );

  rlpg_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pos),
    .divisor  (hue_span),
    .done     (div_done),
    .quotient (div_quo)
  );

  rlpg_hue_rgb u_hue (
    .clk    (clk),
    .rst    (rst),
    .start  (hue_start),
    .offset (div_quo),
    .phase  (phase),
    .valid  (hue_valid),
    .rgb    (hue_rgb)
  );

  // mul_start is combinational so the multiplier latches dt on accept
  assign mul_start = req_acc && (req.func == FUNC_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      div_start <= 1'b0;
      hue_start <= 1'b0;
      pix.valid <= 1'b0;
      pix_i     <= '0;
      pos       <= '0;
      n         <= '0;
    end else begin
      div_start <= (state == S_IDLE && req_acc && req.func == FUNC_RENDER && enable &&
                    hue_span != '0 && n_next != '0) ||
                   (state == S_EMIT && pix_free && !is_last);
      hue_start <= (state == S_DIV) && div_done;
      pix.valid <= (state == S_EMIT && pix_free) || (pix.valid && !pix.ready);
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            if (req.func == FUNC_TICK) begin
              state <= S_TICK;
            end else if (enable && hue_span != '0 && n_next != '0) begin
              n     <= n_next;
              pix_i <= '0;
              pos   <= '0;
              state <= S_DIV;
            end
          end
        end
        S_TICK: begin
          if (mul_done) begin
            phase <= phase + mul_result;
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_COLOR;
          end
        end
        S_COLOR: begin
          if (hue_valid) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (pix_free) begin
            pix.pixel_index <= pix_i[IDX_W-1:0];
            pix.red         <= hue_rgb.red;
            pix.green       <= hue_rgb.green;
            pix.blue        <= hue_rgb.blue;
            pix.last        <= is_last;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              pix_i <= pix_i + 1'b1;
              pos   <= ((pos + 1'b1) == hue_span) ? '0 : pos + 1'b1;
              state <= S_DIV;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_phase_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    state != S_TICK |=> $stable(phase))
    else $error("phase changed outside a tick");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  a_hue_valid_in_color: assert property (@(posedge clk) disable iff (rst)
    hue_valid |-> state == S_COLOR)
    else $error("color result arrived outside the color step");

  a_pix_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(pix.valid) |-> $past(state) == S_EMIT && $past(pix_i) < $past(n))
    else $error("pixel presented outside an emit step or past the count");

endmodule
`default_nettype wire

FILE: sv/rlpg_serial_mul.sv
`default_nettype none
module rlpg_serial_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rlpg_pkg::DT_W-1:0]     a,
  input  logic [rlpg_pkg::SPEED_W-1:0]  b,
  output logic                          done,
  output logic [rlpg_pkg::PHASE_W-1:0]  result
);
  import rlpg_pkg::*;

  logic                    busy;
  logic [STEP_CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]       prod;
  logic [SPEED_W-1:0]      mcand;
  logic [SPEED_W:0]        sum;

  // one multiplier bit per cycle, partial sum in the upper half
  always_comb begin
    sum = {1'b0, prod[PROD_W-1:DT_W]} + (prod[0] ? {1'b0, mcand} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == STEP_CNT_W'(DT_W - 1));
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        prod  <= {{SPEED_W{1'b0}}, a};
        mcand <= b;
      end else if (busy) begin
        prod <= {sum, prod[DT_W-1:1]};
        cnt  <= cnt + 1'b1;
        if (cnt == STEP_CNT_W'(DT_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign result = prod[FRAC_SHIFT +: PHASE_W];
endmodule
`default_nettype wire

FILE: sv/rlpg_serial_div.sv
`default_nettype none
module rlpg_serial_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rlpg_pkg::SPAN_W-1:0]   dividend,
  input  logic [rlpg_pkg::SPAN_W-1:0]   divisor,
  output logic                          done,
  output logic [rlpg_pkg::PHASE_W-1:0]  quotient
);
  import rlpg_pkg::*;

  logic                    busy;
  logic [STEP_CNT_W-1:0]   cnt;
  logic [SPAN_W-1:0]       rem;
  logic [SPAN_W-1:0]       dsor;
  logic [PHASE_W-1:0]      quo;
  logic [SPAN_W:0]         trial;
  logic [SPAN_W:0]         diff;
  logic                    fits;

  // restoring division of dividend * 2^16, one quotient bit per cycle
  always_comb begin
    trial = {rem, 1'b0};
    diff  = trial - {1'b0, dsor};
    fits  = trial >= {1'b0, dsor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == STEP_CNT_W'(PHASE_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= dividend;
        dsor <= divisor;
        quo  <= '0;
      end else if (busy) begin
        rem <= fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
        quo <= {quo[PHASE_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == STEP_CNT_W'(PHASE_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;
endmodule
`default_nettype wire

FILE: sv/rlpg_hue_rgb.sv
`default_nettype none
module rlpg_hue_rgb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rlpg_pkg::PHASE_W-1:0]  offset,
  input  logic [rlpg_pkg::PHASE_W-1:0]  phase,
  output logic                          valid,
  output rlpg_pkg::rgb_t                rgb
);
  import rlpg_pkg::*;

  localparam logic [2:0] SEC_RED_GREEN_UP  = 3'd0;
  localparam logic [2:0] SEC_RED_DOWN      = 3'd1;
  localparam logic [2:0] SEC_BLUE_UP       = 3'd2;
  localparam logic [2:0] SEC_GREEN_DOWN    = 3'd3;
  localparam logic [2:0] SEC_RED_UP        = 3'd4;

  localparam int RAMP_W  = PHASE_W + 1;
  localparam int SCALE_W = RAMP_W + CH_W;

  logic [PHASE_W-1:0]  hue;
  logic [PHASE_W+2:0]  s6;
  logic [RAMP_W-1:0]   ramp_next;
  logic                stage1;
  logic [2:0]          sector;
  logic [RAMP_W-1:0]   ramp;
  logic [SCALE_W-1:0]  scaled;
  logic [CH_W-1:0]     x;
  rgb_t                rgb_next;

  always_comb begin
    hue       = offset + phase;
    s6        = (PHASE_W + 3)'({hue, 2'b00}) + (PHASE_W + 3)'({hue, 1'b0});
    ramp_next = s6[PHASE_W] ? (RAMP_W'(1) << PHASE_W) - {1'b0, s6[PHASE_W-1:0]}
                            : {1'b0, s6[PHASE_W-1:0]};
  end

  // ramp * 255 >> 16
  always_comb begin
    scaled = {ramp, {CH_W{1'b0}}} - SCALE_W'(ramp);
    x      = scaled[PHASE_W +: CH_W];
    case (sector)
      SEC_RED_GREEN_UP: rgb_next = '{red: '1, green: x,  blue: '0};
      SEC_RED_DOWN:     rgb_next = '{red: x,  green: '1, blue: '0};
      SEC_BLUE_UP:      rgb_next = '{red: '0, green: '1, blue: x};
      SEC_GREEN_DOWN:   rgb_next = '{red: '0, green: x,  blue: '1};
      SEC_RED_UP:       rgb_next = '{red: x,  green: '0, blue: '1};
      default:          rgb_next = '{red: '1, green: '0, blue: x};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      valid  <= 1'b0;
    end else begin
      stage1 <= start;
      valid  <= stage1;
      if (start) begin
        sector <= s6[PHASE_W+2:PHASE_W];
        ramp   <= ramp_next;
      end
      if (stage1) begin
        rgb <= rgb_next;
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/tb_rainbow_led_pattern_generator_unit.sv
`default_nettype none
module tb_rainbow_led_pattern_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rlpg_pkg::*;

  localparam int MAX_PIXELS  = 64;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int QUIET_WAIT  = 64;
  localparam int SEGMENTS    = 12;
  localparam int SEG_ITEMS   = 38;
  localparam int PLAN_ROWS   = 26;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last;
  } pixel_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_CHECK
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_reg_t              sel;
    logic [CFG_DATA_W-1:0] data;
    logic                  func;
    logic [DT_W-1:0]       dt;
    pixel_t                pix;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rlpg_req_if req();
  rlpg_pix_if pix();

  rainbow_led_pattern_generator_unit #(
    .MAX_PIXELS(MAX_PIXELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req),
    .pix(pix)
  );

  always #4 clk = ~clk;

  // predictor state
  logic               cur_enable = 1'b0;
  logic [SPAN_W-1:0]  cur_span   = '0;
  logic [COUNT_W-1:0] cur_count  = '0;
  logic [SPEED_W-1:0] cur_speed  = SPEED_RESET;
  logic [PHASE_W-1:0] cur_phase  = '0;
  pixel_t pending_pixels[$];

  logic   typed_on;
  pixel_t typed_pix;

  int send_idle_pct = 17;
  int recv_idle_pct = 61;
  int hold_len  = 0;
  int hold_tag  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int n_errors  = 0;
  int n_checked = 0;
  int n_ticks   = 0;
  int n_frames  = 0;
  int cycles    = 0;

  plan_row_t plan [PLAN_ROWS];
  pixel_t seen_pix;
  pixel_t want_pix;

  function automatic string pix_str(pixel_t p);
    return $sformatf("idx=%0d rgb=(%0d,%0d,%0d) last=%0b",
                     p.pixel_index, p.red, p.green, p.blue, p.last);
  endfunction

  function automatic void log_mismatch(string what);
    n_errors++;
    if (n_errors <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endfunction

  function automatic pixel_t shade_pixel(int unsigned i, int unsigned n);
    int unsigned span;
    int unsigned offset;
    int unsigned s6;
    int unsigned ramp;
    logic [PHASE_W-1:0] hue;
    logic [2:0]         sector;
    logic [CH_W-1:0]    level;
    pixel_t p;
    span   = cur_span;
    offset = ((i % span) << 16) / span;
    hue    = PHASE_W'(offset) + cur_phase;
    s6     = 32'(hue) * 6;
    sector = 3'(s6 >> 16);
    ramp   = sector[0] ? 32'd65536 - (s6 & 32'hFFFF) : (s6 & 32'hFFFF);
    level  = CH_W'((ramp * 255) >> 16);
    p.pixel_index = IDX_W'(i);
    p.last        = (i + 1 == n);
    case (sector)
      3'd0: begin
        p.red = 8'd255; p.green = level;  p.blue = 8'd0;
      end
      3'd1: begin
        p.red = level;  p.green = 8'd255; p.blue = 8'd0;
      end
      3'd2: begin
        p.red = 8'd0;   p.green = 8'd255; p.blue = level;
      end
      3'd3: begin
        p.red = 8'd0;   p.green = level;  p.blue = 8'd255;
      end
      3'd4: begin
        p.red = level;  p.green = 8'd0;   p.blue = 8'd255;
      end
      default: begin
        p.red = 8'd255; p.green = 8'd0;   p.blue = level;
      end
    endcase
    return p;
  endfunction

  function automatic void predict_frame();
    int unsigned n;
    if (!cur_enable || cur_span == 0) begin
      return;
    end
    n = (cur_count > MAX_PIXELS) ? MAX_PIXELS : cur_count;
    for (int unsigned i = 0; i < n; i++) begin
      pending_pixels.push_back(shade_pixel(i, n));
    end
  endfunction

  function automatic void advance_phase(logic [DT_W-1:0] dt);
    logic [PROD_W-1:0] prod;
    prod      = PROD_W'(dt) * PROD_W'(cur_speed);
    cur_phase = cur_phase + PHASE_W'(prod >> FRAC_SHIFT);
  endfunction

  // scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (pix.valid && pix.ready) begin
        seen_pix = '{pix.pixel_index, pix.red, pix.green, pix.blue, pix.last};
        if (pending_pixels.size() == 0) begin
          log_mismatch($sformatf("unexpected pixel %s", pix_str(seen_pix)));
        end else begin
          want_pix = pending_pixels.pop_front();
          n_checked++;
          if (seen_pix.pixel_index !== want_pix.pixel_index ||
              seen_pix.red !== want_pix.red || seen_pix.green !== want_pix.green ||
              seen_pix.blue !== want_pix.blue || seen_pix.last !== want_pix.last) begin
            log_mismatch($sformatf("expected %s got %s",
                                   pix_str(want_pix), pix_str(seen_pix)));
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.func == FUNC_TICK) begin
          n_ticks++;
          advance_phase(req.dt);
        end else begin
          n_frames++;
          if (typed_on) begin
            pending_pixels.push_back(typed_pix);
          end else begin
            predict_frame();
          end
        end
      end
    end
  end

  // pixel receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      pix.ready <= 1'b0;
    end else begin
      pix.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding",
               cycles, pending_pixels.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(logic func, logic [DT_W-1:0] dt, logic typed, pixel_t tp);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.func  <= func;
    req.dt    <= dt;
    typed_on  <= typed;
    typed_pix <= tp;
    @(posedge clk);
    while (!req.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    case (sel)
      CFG_ENABLE:      cur_enable = data[0];
      CFG_HUE_SPAN:    cur_span   = data[SPAN_W-1:0];
      CFG_PIXEL_COUNT: cur_count  = data[COUNT_W-1:0];
      CFG_SPIN_RATE:   cur_speed  = data[SPEED_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // ticks and empty frames give no pixels, so let the block settle after the last one
  task automatic wait_quiet();
    req.valid <= 1'b0;
    cfg_we    <= 1'b0;
    while (pending_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (QUIET_WAIT) @(negedge clk);
  endtask

  initial begin
    logic            dirty;
    int unsigned     span;
    int unsigned     count;
    logic [SPEED_W-1:0] speed;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    req.valid = 1'b0;
    req.func  = FUNC_TICK;
    req.dt    = '0;
    typed_on  = 1'b0;
    typed_pix = '0;

    plan = '{
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_RENDER, 16'd0,     '0},
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_TICK,   16'd0,     '0},
      '{ROW_CFG,   CFG_ENABLE,      16'd1,     FUNC_TICK,   16'd0,     '0},
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_RENDER, 16'hFFFF,  '0},
      '{ROW_CFG,   CFG_HUE_SPAN,    16'd1,     FUNC_TICK,   16'd0,     '0},
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_RENDER, 16'd0,     '0},
      '{ROW_CFG,   CFG_PIXEL_COUNT, 16'd1,     FUNC_TICK,   16'd0,     '0},
      '{ROW_CHECK, CFG_ENABLE,      16'd0,     FUNC_RENDER, 16'd0,
        '{6'd0, 8'd255, 8'd0, 8'd0, 1'b1}},
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_TICK,   16'd16384, '0},
      '{ROW_CHECK, CFG_ENABLE,      16'd0,     FUNC_RENDER, 16'd0,
        '{6'd0, 8'd127, 8'd255, 8'd0, 1'b1}},
      '{ROW_CFG,   CFG_HUE_SPAN,    16'd6,     FUNC_TICK,   16'd0,     '0},
      '{ROW_CFG,   CFG_PIXEL_COUNT, 16'd6,     FUNC_TICK,   16'd0,     '0},
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_RENDER, 16'd0,     '0},
      '{ROW_CFG,   CFG_SPIN_RATE,   16'hFFFF,  FUNC_TICK,   16'd0,     '0},
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_TICK,   16'hFFFF,  '0},
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_RENDER, 16'd0,     '0},
      '{ROW_CFG,   CFG_SPIN_RATE,   16'd0,     FUNC_TICK,   16'd0,     '0},
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_TICK,   16'hFFFF,  '0},
      '{ROW_CFG,   CFG_PIXEL_COUNT, 16'd127,   FUNC_TICK,   16'd0,     '0},
      '{ROW_CFG,   CFG_HUE_SPAN,    16'd127,   FUNC_TICK,   16'd0,     '0},
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_RENDER, 16'd0,     '0},
      '{ROW_CFG,   CFG_HUE_SPAN,    16'd64,    FUNC_TICK,   16'd0,     '0},
      '{ROW_CFG,   CFG_PIXEL_COUNT, 16'd64,    FUNC_TICK,   16'd0,     '0},
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_RENDER, 16'd0,     '0},
      '{ROW_CFG,   CFG_ENABLE,      16'd0,     FUNC_TICK,   16'd0,     '0},
      '{ROW_ITEM,  CFG_ENABLE,      16'd0,     FUNC_RENDER, 16'd0,     '0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    dirty = 1'b0;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        if (dirty) begin
          wait_quiet();
        end
        dirty = 1'b0;
        write_reg(plan[r].sel, plan[r].data);
      end else begin
        dirty = 1'b1;
        send_item(plan[r].func, plan[r].dt, plan[r].kind == ROW_CHECK, plan[r].pix);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_quiet();
      if (seg < 4) begin
        send_idle_pct = 17;
        recv_idle_pct = 61;
      end else if (seg < 8) begin
        send_idle_pct = 61;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (seg == 8) begin
        // receiver stalls while frames keep coming, then the sender waits it out
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_HUE_SPAN, 16'd3);
        write_reg(CFG_PIXEL_COUNT, 16'd5);
        hold_len = 700;
        hold_tag++;
        for (int k = 0; k < 10; k++) begin
          send_item(FUNC_RENDER, 16'($urandom), 1'b0, '0);
        end
        wait_quiet();
      end

      case ($urandom_range(9))
        0:       span = 0;
        1:       span = 1;
        2:       span = 64;
        3:       span = 127;
        4:       span = $urandom_range(65, 126);
        default: span = $urandom_range(2, 16);
      endcase
      case ($urandom_range(9))
        0:       count = 0;
        1:       count = 64;
        2:       count = $urandom_range(65, 127);
        default: count = $urandom_range(1, 12);
      endcase
      case ($urandom_range(5))
        0:       speed = '0;
        1:       speed = '1;
        2:       speed = SPEED_RESET;
        default: speed = SPEED_W'($urandom);
      endcase
      write_reg(CFG_ENABLE, {15'($urandom), 1'($urandom_range(7) != 0)});
      write_reg(CFG_HUE_SPAN, {9'($urandom), 7'(span)});
      write_reg(CFG_PIXEL_COUNT, {9'($urandom), 7'(count)});
      write_reg(CFG_SPIN_RATE, speed);

      for (int k = 0; k < SEG_ITEMS; k++) begin
        send_item(1'($urandom_range(1)), 16'($urandom), 1'b0, '0);
      end
    end

    wait_quiet();
    $display("%0d transactions in (%0d ticks, %0d frames), %0d pixels checked",
             n_ticks + n_frames, n_ticks, n_frames, n_checked);
    $display("%0d setups across three idle patterns and one long receiver stall, %0d errors",
             SEGMENTS, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
